>>> hdl/cvu_pkg.sv
// Package for the constrained velocity update: request types, codes and arithmetic helpers.
`default_nettype none

package cvu_pkg;

    // Pipeline depths of the iterative units
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SPEED_SQ  = 2'd0,
        CFG_TIME_STEP = 2'd1,
        CFG_POS_MOVE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] noise_x;
        logic signed [31:0] noise_y;
        logic signed [31:0] noise_z;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               renormalized;
        logic [31:0]        fail_count;
    } t_out_req;

    typedef logic [2:0][31:0] t_vec3;

    // Per-particle data that rides along the long sqrt and divide pipes
    typedef struct packed {
        t_vec3       v;
        t_vec3       dv;
        t_vec3       u;
        t_vec3       np;
        logic [31:0] b;
        logic [31:0] c;
        logic        root;
        logic        mzero;
        logic [31:0] fcnt;
    } t_side;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } t_sqrt;

    function automatic logic signed [63:0] ext64(input logic signed [31:0] x);
        ext64 = x;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic signed [63:0] e;
        e = ext64(x);
        if (x < 0) begin
            mag32 = 32'(-e);
        end else begin
            mag32 = x;
        end
    endfunction

    // One digit of the bit-pair square root
    function automatic t_sqrt sqrt_step(input t_sqrt cur, input logic [63:0] bitv);
        t_sqrt nxt;
        if (cur.x >= cur.r + bitv) begin
            nxt.x = cur.x - (cur.r + bitv);
            nxt.r = (cur.r >> 1) + bitv;
        end else begin
            nxt.x = cur.x;
            nxt.r = cur.r >> 1;
        end
        sqrt_step = nxt;
    endfunction

endpackage

`default_nettype wire

>>> hdl/constrained_velocity_update_top.sv
// Top level: pipelined constrained velocity and position update for one particle per request.
// Throughput: one request per cycle unless the output stalls.
// The 32-stage square root and 32-stage divide pipes set depth.
// A stalled output freezes the whole pipe; nothing is lost or repeated.
// Reset (synchronous, active low) clears valids, the failure counter and restores config values.
`default_nettype none

module constrained_velocity_update_top (
    input  wire                logic         i_clk,
    input  wire                logic         i_rst_n,
    input  wire                logic         i_valid,
    output                     logic         o_stall,
    input  wire  cvu_pkg::t_in_req           i_data,
    output                     logic         o_valid,
    input  wire                logic         i_stall,
    output cvu_pkg::t_out_req                o_data,
    input  wire                logic         i_cfg_we,
    input  wire                logic [1:0]   i_cfg_idx,
    input  wire                logic [31:0]  i_cfg_data
);
    import cvu_pkg::*;

    logic w_adv;

    // Configuration
    logic [31:0] r_speed_sq;
    logic [31:0] r_time_step;
    logic        r_pos_move;
    logic [31:0] r_fail_cnt;
    logic [31:0] n_fail_cnt;

    // Stage valids
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_s8_vld;
    logic r_sq_vld [0:SQRT_STAGES];
    logic r_sn_vld;
    logic r_dv_vld [1:DIV_STAGES];
    logic r_sw_vld, r_sx_vld, r_sy_vld;

    // Stage data
    t_in_req            r_s1_in;
    logic signed [31:0] r_s2_p [3];
    logic signed [31:0] r_s2_v [3];
    logic signed [31:0] r_s2_n [3];
    logic signed [63:0] r_s2_pv [3];
    logic signed [63:0] r_s2_tf [3];
    logic signed [31:0] r_s3_v [3];
    logic signed [31:0] r_s3_np [3];
    logic signed [31:0] r_s3_t [3];
    logic signed [31:0] r_s4_v [3];
    logic signed [31:0] r_s4_np [3];
    logic signed [63:0] r_s4_at [3];
    logic signed [31:0] r_s5_v [3];
    logic signed [31:0] r_s5_np [3];
    logic signed [31:0] r_s5_dv [3];
    logic signed [31:0] r_s6_v [3];
    logic signed [31:0] r_s6_np [3];
    logic signed [31:0] r_s6_dv [3];
    logic signed [31:0] r_s6_u [3];
    logic signed [63:0] r_s6_vdv [3];
    logic signed [63:0] r_s6_dd [3];
    logic signed [31:0] r_s7_v [3];
    logic signed [31:0] r_s7_np [3];
    logic signed [31:0] r_s7_dv [3];
    logic signed [31:0] r_s7_u [3];
    logic [63:0]        r_s7_uu [3];
    logic signed [31:0] r_s7_b;
    logic signed [31:0] r_s7_c;
    logic signed [31:0] r_s8_v [3];
    logic signed [31:0] r_s8_np [3];
    logic signed [31:0] r_s8_dv [3];
    logic signed [31:0] r_s8_u [3];
    logic signed [31:0] r_s8_b;
    logic signed [31:0] r_s8_c;
    logic [63:0]        r_s8_b2;
    logic [63:0]        r_s8_ac;
    logic [63:0]        r_s8_m;

    t_side       r_sq_side [0:SQRT_STAGES];
    t_sqrt       r_sq_main [0:SQRT_STAGES];
    t_sqrt       r_sq_spd  [0:SQRT_STAGES];

    t_side       r_sn_side;
    logic [63:0] r_sn_num [3];
    logic [63:0] r_sn_den;
    logic        r_sn_neg [3];

    t_side       r_dv_side [1:DIV_STAGES];
    logic [63:0] r_dv_rem  [1:DIV_STAGES][3];
    logic [31:0] r_dv_q    [1:DIV_STAGES][3];
    logic        r_dv_ovf  [1:DIV_STAGES][3];
    logic        r_dv_neg  [1:DIV_STAGES][3];
    logic [63:0] r_dv_den  [1:DIV_STAGES];

    t_side              r_sw_side;
    logic signed [31:0] r_sw_l [3];
    t_side              r_sx_side;
    logic signed [31:0] r_sx_l [3];
    logic signed [63:0] r_sx_wv [3];
    t_out_req           r_sy_data;

    // Combinational helpers
    logic [32:0]        w_dt;
    logic [32:0]        w_ts;
    logic [32:0]        w_a;
    logic signed [31:0] w_p [3];
    logic signed [31:0] w_v [3];
    logic signed [31:0] w_f [3];
    logic signed [31:0] w_n [3];
    logic signed [63:0] w_b2s;
    logic               w_root;
    logic [63:0]        w_d;

    // Hold the whole pipe while a finished result is refused
    assign w_adv   = !(r_sy_vld && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_sy_vld;
    assign o_data  = r_sy_data;

    assign w_dt = r_pos_move ? {1'b0, r_time_step} : 33'd0;
    assign w_ts = {1'b0, r_time_step};
    assign w_a  = {1'b0, r_speed_sq};

    assign w_p[0] = r_s1_in.pos_x;   assign w_p[1] = r_s1_in.pos_y;   assign w_p[2] = r_s1_in.pos_z;
    assign w_v[0] = r_s1_in.vel_x;   assign w_v[1] = r_s1_in.vel_y;   assign w_v[2] = r_s1_in.vel_z;
    assign w_f[0] = r_s1_in.force_x; assign w_f[1] = r_s1_in.force_y; assign w_f[2] = r_s1_in.force_z;
    assign w_n[0] = r_s1_in.noise_x; assign w_n[1] = r_s1_in.noise_y; assign w_n[2] = r_s1_in.noise_z;

    // Root test on B*B against speed_sq*C
    assign w_b2s  = $signed(r_s7_b) * $signed(r_s7_b);
    assign w_root = (r_speed_sq != 32'd0) && ((r_s8_c <= 0) || (r_s8_b2 >= r_s8_ac));
    assign w_d    = (r_s8_c <= 0) ? (r_s8_b2 + r_s8_ac) : (r_s8_b2 - r_s8_ac);

    assign n_fail_cnt = (!w_root && (r_fail_cnt != 32'hffffffff)) ? r_fail_cnt + 32'd1
                                                                 : r_fail_cnt;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_sq  <= 32'd16777216;
            r_time_step <= 32'd42950;
            r_pos_move  <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SPEED_SQ:  r_speed_sq  <= i_cfg_data;
                CFG_TIME_STEP: r_time_step <= i_cfg_data;
                CFG_POS_MOVE:  r_pos_move  <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Advance the saturating failure count in request order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_cnt <= 32'd0;
        end else if (w_adv && r_s8_vld) begin
            r_fail_cnt <= n_fail_cnt;
        end
    end

    // Shift valid bits along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0; r_s2_vld <= 1'b0; r_s3_vld <= 1'b0; r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0; r_s6_vld <= 1'b0; r_s7_vld <= 1'b0; r_s8_vld <= 1'b0;
            for (int j = 0; j <= SQRT_STAGES; j++) r_sq_vld[j] <= 1'b0;
            r_sn_vld <= 1'b0;
            for (int j = 1; j <= DIV_STAGES; j++) r_dv_vld[j] <= 1'b0;
            r_sw_vld <= 1'b0; r_sx_vld <= 1'b0; r_sy_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld; r_s3_vld <= r_s2_vld; r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld; r_s6_vld <= r_s5_vld; r_s7_vld <= r_s6_vld;
            r_s8_vld <= r_s7_vld;
            r_sq_vld[0] <= r_s8_vld;
            for (int j = 1; j <= SQRT_STAGES; j++) r_sq_vld[j] <= r_sq_vld[j-1];
            r_sn_vld <= r_sq_vld[SQRT_STAGES];
            r_dv_vld[1] <= r_sn_vld;
            for (int j = 2; j <= DIV_STAGES; j++) r_dv_vld[j] <= r_dv_vld[j-1];
            r_sw_vld <= r_dv_vld[DIV_STAGES];
            r_sx_vld <= r_sw_vld;
            r_sy_vld <= r_sx_vld;
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        logic signed [63:0] v_bsum;
        logic signed [63:0] v_dsum;
        t_side              v_side;
        logic [31:0]        v_s;
        logic [31:0]        v_sa;
        logic [31:0]        v_bmag;
        logic [95:0]        v_dsh;
        logic [31:0]        v_q;
        logic signed [31:0] v_l;
        if (w_adv) begin
            // Stage 1: capture request
            r_s1_in <= i_data;

            // Stage 2: position and force products
            for (int i = 0; i < 3; i++) begin
                r_s2_p[i]  <= w_p[i];
                r_s2_v[i]  <= w_v[i];
                r_s2_n[i]  <= w_n[i];
                r_s2_pv[i] <= $signed(w_v[i]) * $signed(w_dt);
                r_s2_tf[i] <= $signed(w_f[i]) * $signed(w_ts);
            end

            // Stage 3: new position and scaled force plus noise
            for (int i = 0; i < 3; i++) begin
                r_s3_v[i]  <= r_s2_v[i];
                r_s3_np[i] <= sat32(ext64(r_s2_p[i]) + (r_s2_pv[i] >>> 40));
                r_s3_t[i]  <= sat32((r_s2_tf[i] >>> 32) + ext64(r_s2_n[i]));
            end

            // Stage 4: multiply by speed_sq
            for (int i = 0; i < 3; i++) begin
                r_s4_v[i]  <= r_s3_v[i];
                r_s4_np[i] <= r_s3_np[i];
                r_s4_at[i] <= $signed(r_s3_t[i]) * $signed(w_a);
            end

            // Stage 5: velocity change
            for (int i = 0; i < 3; i++) begin
                r_s5_v[i]  <= r_s4_v[i];
                r_s5_np[i] <= r_s4_np[i];
                r_s5_dv[i] <= sat32(r_s4_at[i] >>> 24);
            end

            // Stage 6: dot products and fallback sum
            for (int i = 0; i < 3; i++) begin
                r_s6_v[i]   <= r_s5_v[i];
                r_s6_np[i]  <= r_s5_np[i];
                r_s6_dv[i]  <= r_s5_dv[i];
                r_s6_u[i]   <= sat32(ext64(r_s5_v[i]) + ext64(r_s5_dv[i]));
                r_s6_vdv[i] <= $signed(r_s5_v[i]) * $signed(r_s5_dv[i]);
                r_s6_dd[i]  <= $signed(r_s5_dv[i]) * $signed(r_s5_dv[i]);
            end

            // Stage 7: quadratic terms B and C, squares of the fallback vector
            v_bsum = (r_s6_vdv[0] >>> 24) + (r_s6_vdv[1] >>> 24) + (r_s6_vdv[2] >>> 24);
            v_dsum = (r_s6_dd[0] >>> 24) + (r_s6_dd[1] >>> 24) + (r_s6_dd[2] >>> 24)
                   - $signed({32'd0, r_speed_sq});
            r_s7_b <= sat32(v_bsum);
            r_s7_c <= sat32(v_dsum);
            for (int i = 0; i < 3; i++) begin
                r_s7_v[i]  <= r_s6_v[i];
                r_s7_np[i] <= r_s6_np[i];
                r_s7_dv[i] <= r_s6_dv[i];
                r_s7_u[i]  <= r_s6_u[i];
                r_s7_uu[i] <= $signed(r_s6_u[i]) * $signed(r_s6_u[i]);
            end

            // Stage 8: discriminant parts and fallback length
            r_s8_b  <= r_s7_b;
            r_s8_c  <= r_s7_c;
            r_s8_b2 <= w_b2s;
            r_s8_ac <= {32'd0, r_speed_sq} * {32'd0, mag32(r_s7_c)};
            r_s8_m  <= (r_s7_uu[0] >> 2) + (r_s7_uu[1] >> 2) + (r_s7_uu[2] >> 2);
            for (int i = 0; i < 3; i++) begin
                r_s8_v[i]  <= r_s7_v[i];
                r_s8_np[i] <= r_s7_np[i];
                r_s8_dv[i] <= r_s7_dv[i];
                r_s8_u[i]  <= r_s7_u[i];
            end

            // Stage 9: pick the root or fallback radicand
            for (int i = 0; i < 3; i++) begin
                v_side.v[i]  = r_s8_v[i];
                v_side.dv[i] = r_s8_dv[i];
                v_side.u[i]  = r_s8_u[i];
                v_side.np[i] = r_s8_np[i];
            end
            v_side.b     = r_s8_b;
            v_side.c     = r_s8_c;
            v_side.root  = w_root;
            v_side.mzero = (r_s8_m == 64'd0);
            v_side.fcnt  = n_fail_cnt;
            r_sq_side[0]  <= v_side;
            r_sq_main[0].x <= w_root ? w_d : r_s8_m;
            r_sq_main[0].r <= 64'd0;
            r_sq_spd[0].x  <= {8'd0, r_speed_sq, 24'd0};
            r_sq_spd[0].r  <= 64'd0;

            // Square root pipes: one result bit per stage
            for (int j = 1; j <= SQRT_STAGES; j++) begin
                r_sq_side[j] <= r_sq_side[j-1];
                r_sq_main[j] <= sqrt_step(r_sq_main[j-1], 64'd1 << (2 * (SQRT_STAGES - j)));
                r_sq_spd[j]  <= sqrt_step(r_sq_spd[j-1], 64'd1 << (2 * (SQRT_STAGES - j)));
            end

            // Numerators and shared denominator
            v_side = r_sq_side[SQRT_STAGES];
            v_s    = r_sq_main[SQRT_STAGES].r[31:0];
            v_sa   = r_sq_spd[SQRT_STAGES].r[31:0];
            v_bmag = mag32(v_side.b);
            r_sn_side <= v_side;
            if (v_side.root) begin
                if ($signed(v_side.b) > 0) begin
                    r_sn_num[0] <= {8'd0, mag32(v_side.c), 24'd0};
                    r_sn_den    <= {32'd0, v_side.b} + {32'd0, v_s};
                end else begin
                    r_sn_num[0] <= ({32'd0, v_s} + {32'd0, v_bmag}) << 24;
                    r_sn_den    <= {32'd0, r_speed_sq};
                end
                // Negate only on the -C / (B + s) form with positive C
                r_sn_neg[0] <= ($signed(v_side.b) > 0) && ($signed(v_side.c) > 0);
                for (int i = 1; i < 3; i++) begin
                    r_sn_num[i] <= 64'd0;
                    r_sn_neg[i] <= 1'b0;
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_sn_num[i] <= {32'd0, mag32(v_side.u[i])} * {32'd0, v_sa};
                    r_sn_neg[i] <= v_side.u[i][31];
                end
                r_sn_den <= v_side.mzero ? 64'd1 : {31'd0, v_s, 1'b0};
            end

            // Divide stage 1: flag quotients that reach 2^31
            r_dv_side[1] <= r_sn_side;
            r_dv_den[1]  <= r_sn_den;
            v_dsh = {32'd0, r_sn_den} << 31;
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[1][i] <= r_sn_num[i];
                r_dv_q[1][i]   <= 32'd0;
                r_dv_ovf[1][i] <= ({32'd0, r_sn_num[i]} >= v_dsh);
                r_dv_neg[1][i] <= r_sn_neg[i];
            end

            // Divide stages: one quotient bit per stage
            for (int j = 2; j <= DIV_STAGES; j++) begin
                r_dv_side[j] <= r_dv_side[j-1];
                r_dv_den[j]  <= r_dv_den[j-1];
                v_dsh = {32'd0, r_dv_den[j-1]} << (DIV_STAGES - j);
                for (int i = 0; i < 3; i++) begin
                    r_dv_ovf[j][i] <= r_dv_ovf[j-1][i];
                    r_dv_neg[j][i] <= r_dv_neg[j-1][i];
                    if ({32'd0, r_dv_rem[j-1][i]} >= v_dsh) begin
                        r_dv_rem[j][i] <= r_dv_rem[j-1][i] - v_dsh[63:0];
                        r_dv_q[j][i]   <= r_dv_q[j-1][i] | (32'd1 << (DIV_STAGES - j));
                    end else begin
                        r_dv_rem[j][i] <= r_dv_rem[j-1][i];
                        r_dv_q[j][i]   <= r_dv_q[j-1][i];
                    end
                end
            end

            // Sign and saturate quotients
            r_sw_side <= r_dv_side[DIV_STAGES];
            for (int i = 0; i < 3; i++) begin
                v_q = r_dv_q[DIV_STAGES][i];
                if (r_dv_ovf[DIV_STAGES][i]) begin
                    v_l = r_dv_neg[DIV_STAGES][i] ? 32'sh80000000 : 32'sh7fffffff;
                end else begin
                    v_l = r_dv_neg[DIV_STAGES][i] ? $signed(~v_q + 32'd1) : $signed(v_q);
                end
                r_sw_l[i] <= v_l;
            end

            // Multiplier times old velocity
            r_sx_side <= r_sw_side;
            for (int i = 0; i < 3; i++) begin
                r_sx_l[i]  <= r_sw_l[i];
                r_sx_wv[i] <= $signed(r_sw_l[0]) * $signed(r_sw_side.v[i]);
            end

            // Final velocity select into the output register
            v_side = r_sx_side;
            for (int i = 0; i < 3; i++) begin
                if (v_side.root) begin
                    v_l = sat32((r_sx_wv[i] >>> 24) + ext64($signed(v_side.dv[i])));
                end else if (v_side.mzero) begin
                    v_l = $signed(v_side.u[i]);
                end else begin
                    v_l = r_sx_l[i];
                end
                case (i)
                    0:       r_sy_data.new_vel_x <= v_l;
                    1:       r_sy_data.new_vel_y <= v_l;
                    default: r_sy_data.new_vel_z <= v_l;
                endcase
            end
            r_sy_data.new_pos_x    <= $signed(v_side.np[0]);
            r_sy_data.new_pos_y    <= $signed(v_side.np[1]);
            r_sy_data.new_pos_z    <= $signed(v_side.np[2]);
            r_sy_data.renormalized <= !v_side.root;
            r_sy_data.fail_count   <= v_side.fcnt;
        end
    end

    // Failure count never steps back while out of reset
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_fail_cnt >= $past(r_fail_cnt))
        else $error("failure count decreased");

    // A renormalized result always carries a nonzero count
    a_flag_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.renormalized |-> o_data.fail_count != 32'd0)
        else $error("renormalized result with zero count");

    // A real root is never taken at zero speed
    a_root_spd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld[0] && r_sq_side[0].root |-> r_speed_sq != 32'd0)
        else $error("root path at zero speed");

endmodule

`default_nettype wire
